### hw/rtl/consumer_renewal_flag_table_unit_macros.svh
// ----------------------------------------------------------------------------
// consumer renewal flag table: assertion macros
// shared helpers for the concurrent checks in the rtl
// ----------------------------------------------------------------------------
`ifndef CONSUMER_RENEWAL_FLAG_TABLE_UNIT_MACROS_SVH
`define CONSUMER_RENEWAL_FLAG_TABLE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CRFT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CRFT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/crft_pkg.sv
// ----------------------------------------------------------------------------
// crft_pkg
// shared types and constants of the consumer renewal flag table
// ----------------------------------------------------------------------------
`default_nettype none

package crft_pkg;

   localparam int ID_W = 32;

   localparam logic CMD_RENEW   = 1'b0;
   localparam logic CMD_CONSUME = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // compare result of one registered id store read
   typedef struct packed {
      logic vld;
      logic match;
   } probe_type;

endpackage

`default_nettype wire

### hw/rtl/crft_id_store.sv
// ----------------------------------------------------------------------------
// crft_id_store
// consumer id memory with one write port, one registered read port and
// a key compare on the read data
// ----------------------------------------------------------------------------
`default_nettype none

module crft_id_store
   import crft_pkg::*;
#(
   parameter int ENTRIES = 8,
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            wr_en,
   input  wire logic [IW-1:0]   wr_addr,
   input  wire logic [ID_W-1:0] wr_data,
   input  wire logic            rd_en,
   input  wire logic [IW-1:0]   rd_addr,
   input  wire logic [ID_W-1:0] key,
   output probe_type            probe
);

   logic [ID_W-1:0] id_mem_ff [ENTRIES];
   logic [ID_W-1:0] rd_data_ff;
   logic            rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= id_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
      end
   end

   assign probe.vld   = rd_vld_ff;
   assign probe.match = (rd_data_ff == key);

endmodule

`default_nettype wire

### hw/rtl/consumer_renewal_flag_table_unit.sv
// ----------------------------------------------------------------------------
// consumer_renewal_flag_table_unit
// tracks which consumers have seen the current value of one location
//
//   channel   ports                                  handshake
//   request   req_command, req_consumer_id           start & !busy
//   response  rsp_was_fresh, rsp_overflow            rsp_valid, one cycle
//
// renew, and consume on an empty table: result in the cycle after the beat.
// consume: entries are read one per cycle from the id memory and compared
// in the cycle after the read; a hit answers at the first matching entry,
// a miss once the last stored entry has been compared.
// busy covers the scan; the response cannot be stalled.
// synchronous reset empties the table and clears all fresh marks at once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "consumer_renewal_flag_table_unit_macros.svh"

module consumer_renewal_flag_table_unit
   import crft_pkg::*;
#(
   parameter int ENTRIES = 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output      logic            busy,
   input  wire logic            req_command,
   input  wire logic [ID_W-1:0] req_consumer_id,
   output      logic            rsp_valid,
   output      logic            rsp_was_fresh,
   output      logic            rsp_overflow
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    issue_ff, issue_in;
   logic [IW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [ENTRIES-1:0] fresh_ff, fresh_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_was_fresh_ff, rsp_was_fresh_in;
   logic             rsp_overflow_ff, rsp_overflow_in;

   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [ID_W-1:0]  wr_data;
   logic             rd_en;
   logic [IW-1:0]    rd_addr;
   probe_type        probe;
   logic [CW-1:0]    cnt_m1;
   logic             last_cmp;
   logic             has_room;

   crft_id_store #(
      .ENTRIES (ENTRIES)
   ) u_id_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .key     (id_ff),
      .probe   (probe)
   );

   assign cnt_m1   = count_ff - CW'(1);
   assign last_cmp = (cmp_idx_ff == cnt_m1[IW-1:0]);
   assign has_room = (count_ff != CW'(ENTRIES));

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      issue_in         = issue_ff;
      fresh_in         = fresh_ff;
      id_in            = id_ff;
      rsp_valid_in     = 1'b0;
      rsp_was_fresh_in = 1'b0;
      rsp_overflow_in  = 1'b0;
      wr_en            = 1'b0;
      wr_addr          = count_ff[IW-1:0];
      wr_data          = id_ff;
      rd_en            = 1'b0;
      rd_addr          = issue_ff[IW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               id_in = req_consumer_id;
               if (req_command == CMD_RENEW) begin
                  // entries past the count are never read, so mark them all
                  fresh_in     = '1;
                  rsp_valid_in = 1'b1;
               end else if (count_ff == '0) begin
                  wr_en            = 1'b1;
                  wr_data          = req_consumer_id;
                  fresh_in[0]      = 1'b0;
                  count_in         = CW'(1);
                  rsp_valid_in     = 1'b1;
                  rsp_was_fresh_in = 1'b1;
               end else begin
                  issue_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff != count_ff) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + CW'(1);
            end
            if (probe.vld) begin
               if (probe.match) begin
                  rsp_valid_in         = 1'b1;
                  rsp_was_fresh_in     = fresh_ff[cmp_idx_ff];
                  fresh_in[cmp_idx_ff] = 1'b0;
                  state_in             = ST_IDLE;
               end else if (last_cmp) begin
                  // unknown consumer: append if there is room
                  rsp_valid_in     = 1'b1;
                  rsp_was_fresh_in = 1'b1;
                  state_in         = ST_IDLE;
                  if (has_room) begin
                     wr_en                      = 1'b1;
                     fresh_in[count_ff[IW-1:0]] = 1'b0;
                     count_in                   = count_ff + CW'(1);
                  end else begin
                     rsp_overflow_in = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign cmp_idx_in = rd_en ? issue_ff[IW-1:0] : cmp_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff         <= issue_in;
      cmp_idx_ff       <= cmp_idx_in;
      id_ff            <= id_in;
      rsp_was_fresh_ff <= rsp_was_fresh_in;
      rsp_overflow_ff  <= rsp_overflow_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_was_fresh = rsp_was_fresh_ff;
   assign rsp_overflow  = rsp_overflow_ff;

   `CRFT_ASSERT_IMP(a_count_range, clock, reset, 1'b1,
      count_ff <= CW'(ENTRIES), "entry count past table size")
   `CRFT_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid_ff,
      state_ff == ST_IDLE, "response while scanning")
   `CRFT_ASSERT_IMP(a_ovf_full, clock, reset, rsp_valid_ff && rsp_overflow_ff,
      rsp_was_fresh_ff && !has_room, "overflow without full table")
   `CRFT_ASSERT_NXT(a_beat_done, clock, reset, start && !busy,
      busy || rsp_valid_ff, "accepted beat left no trace")
   `CRFT_ASSERT_IMP(a_probe_idx, clock, reset, busy && probe.vld,
      CW'(cmp_idx_ff) < count_ff, "compare past stored entries")

endmodule

`default_nettype wire
